@@ hdl/cps_pkg.sv @@
package cps_pkg;

    localparam int CMAP_DEPTH = 16;
    localparam int AW = (CMAP_DEPTH > 1) ? $clog2(CMAP_DEPTH) : 1;
    localparam int NW = $clog2(CMAP_DEPTH + 1);
    localparam int QW = 16 + AW;
    localparam int RW = 26;
    localparam int ST_MEM = AW + 1;
    localparam int ST_NUM = AW + 2;
    localparam int ST_LAST = ST_NUM + 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW = $clog2(FIFO_DEPTH);

    localparam logic [1:0] REG_MIN = 2'd0;
    localparam logic [1:0] REG_MAX = 2'd1;
    localparam logic [1:0] REG_OPACITY = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    typedef enum logic [2:0] {
        CL_WRITE,
        CL_ZERO,
        CL_BLACK,
        CL_FIRST,
        CL_LAST,
        CL_LERP
    } t_cls;

    typedef struct packed {
        logic [15:0] min_value;
        logic [15:0] max_value;
        logic [6:0]  opacity_percent;
        logic [4:0]  entry_count;
    } t_cfg;

    typedef struct packed {
        t_cls        cls;
        logic [15:0] v;
        logic [15:0] d;
        logic [NW-1:0] n;
        logic [3:0]  idx;
        logic [23:0] rgb;
    } t_fe;

    typedef struct packed {
        logic        valid;
        t_cls        cls;
        logic [NW-1:0] n;
        logic [15:0] d;
        logic [3:0]  idx;
        logic [23:0] rgb;
        logic [QW-1:0] rem;
        logic [AW-1:0] iq;
        logic [15:0] r;
        logic [23:0] c0;
        logic [2:0][RW-1:0] rem2;
        logic [2:0][7:0] res;
    } t_bk;

    function automatic logic [7:0] alpha_of(input logic [6:0] op);
        logic [14:0] x;
        logic [27:0] p;
        logic [8:0]  a;
        x = 15'(15'(op) * 15'd255) + 15'd50;
        p = 28'(x) * 28'd5243;
        a = p[27:19];
        return (a > 9'd255) ? 8'd255 : a[7:0];
    endfunction

endpackage

@@ hdl/colormap_pixel_shader.sv @@
// Colormap pixel shader: 16-bit values in, RGBA pixels out.
// Input channel: push/full. An item with i_kind=1 writes colormap entry
// i_entry_index and makes no result; i_kind=0 shades i_value into one pixel.
// Result channel: empty/pop; o_red..o_alpha hold the oldest pixel while
// empty is low.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 min_value,
// 1 max_value, 2 opacity_percent, 3 entry_count); write only while idle.
// Throughput: one item per cycle while results are popped. Path from accept
// to result: front register, queue, 4-step interval divider, table read,
// interpolation multiply, 8-step rounding divider, output register.
// Colormap entries must be written before a pixel reads them.
// Reset clears the registers to their defaults and empties the pipeline;
// the colormap keeps no defined contents.
// When pop stays low the result holds, the back pipeline stops, the
// queue fills, and then full rises.
module colormap_pixel_shader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [15:0] i_value,
    input  logic [3:0]  i_entry_index,
    input  logic [7:0]  i_entry_red,
    input  logic [7:0]  i_entry_green,
    input  logic [7:0]  i_entry_blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha
);
    import cps_pkg::*;

    t_cfg r_cfg;
    t_fe  w_f_item;
    t_fe  w_q_item;
    logic w_f_push, w_q_full, w_q_empty, w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value       <= 16'd0;
            r_cfg.max_value       <= 16'd10;
            r_cfg.opacity_percent <= 7'd100;
            r_cfg.entry_count     <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN:     r_cfg.min_value       <= i_cfg_data;
                REG_MAX:     r_cfg.max_value       <= i_cfg_data;
                REG_OPACITY: r_cfg.opacity_percent <= i_cfg_data[6:0];
                REG_COUNT:   r_cfg.entry_count     <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    cps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_entry_index (i_entry_index),
        .i_rgb         ({i_entry_red, i_entry_green, i_entry_blue}),
        .o_push        (w_f_push),
        .i_q_full      (w_q_full),
        .o_item        (w_f_item)
    );

    cps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_item  (w_f_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    cps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_item    (w_q_item),
        .o_pop     (w_q_pop),
        .empty     (empty),
        .pop       (pop),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue),
        .o_alpha   (o_alpha)
    );

endmodule

@@ hdl/cps_front.sv @@
module cps_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cps_pkg::t_cfg    i_cfg,
    input  logic             i_push,
    output logic             o_full,
    input  logic             i_kind,
    input  logic [15:0]      i_value,
    input  logic [3:0]       i_entry_index,
    input  logic [23:0]      i_rgb,
    output logic             o_push,
    input  logic             i_q_full,
    output cps_pkg::t_fe     o_item
);
    import cps_pkg::*;

    logic r_valid;
    t_fe  r_item;
    t_fe  n_item;
    logic [NW-1:0] w_n;
    logic w_accept;

    assign o_push   = r_valid;
    assign o_full   = r_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_item   = r_item;

    always_comb begin
        if (32'(i_cfg.entry_count) > CMAP_DEPTH) begin
            w_n = NW'(CMAP_DEPTH);
        end else begin
            w_n = NW'(i_cfg.entry_count);
        end
        n_item.v   = i_value - i_cfg.min_value;
        n_item.d   = i_cfg.max_value - i_cfg.min_value;
        n_item.n   = w_n;
        n_item.idx = i_entry_index;
        n_item.rgb = i_rgb;
        if (i_kind) begin
            n_item.cls = CL_WRITE;
        end else if (i_value == 16'hFFFF) begin
            n_item.cls = CL_ZERO;
        end else if (w_n == '0) begin
            n_item.cls = CL_BLACK;
        end else if (w_n == NW'(1) || i_cfg.max_value <= i_cfg.min_value
                     || i_value <= i_cfg.min_value) begin
            n_item.cls = CL_FIRST;
        end else if (i_value >= i_cfg.max_value) begin
            n_item.cls = CL_LAST;
        end else begin
            n_item.cls = CL_LERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hdl/cps_fifo.sv @@
module cps_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cps_pkg::t_fe  i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output cps_pkg::t_fe  o_item
);
    import cps_pkg::*;

    t_fe r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wr;
    logic [FIFO_PW-1:0] r_rd;
    logic [FIFO_PW:0]   r_cnt;
    logic w_push;
    logic w_pop;

    assign o_full  = (r_cnt == (FIFO_PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ hdl/cps_back.sv @@
module cps_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cps_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  cps_pkg::t_fe  i_item,
    output logic          o_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue,
    output logic [7:0]    o_alpha
);
    import cps_pkg::*;

    t_bk r_p [ST_LAST+1];
    t_bk n_p [ST_LAST+1];
    logic [23:0] r_mem [CMAP_DEPTH];
    logic [23:0] r_rd0;
    logic [23:0] r_rd1;
    logic [AW-1:0] w_a0;
    logic [AW-1:0] w_a1;
    logic w_en;
    logic r_out_valid;
    logic [7:0] r_red, r_green, r_blue, r_alpha;

    assign w_en    = !r_out_valid || pop;
    assign o_pop   = w_en && !i_q_empty;
    assign empty   = !r_out_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign o_alpha = r_alpha;

    always_comb begin
        w_a0 = '0;
        if (r_p[AW].cls == CL_LERP) begin
            w_a0 = r_p[AW].iq;
        end else if (r_p[AW].cls == CL_LAST) begin
            w_a0 = AW'(r_p[AW].n - 1'b1);
        end
        w_a1 = (r_p[AW].cls == CL_LERP) ? w_a0 + 1'b1 : w_a0;
    end

    always_comb begin
        logic [QW-1:0] sh;
        logic [RW-1:0] sh2;
        logic [23:0]   num;
        int b;
        n_p[0]       = r_p[0];
        n_p[0].valid = !i_q_empty;
        n_p[0].cls   = i_item.cls;
        n_p[0].n     = i_item.n;
        n_p[0].d     = i_item.d;
        n_p[0].idx   = i_item.idx;
        n_p[0].rgb   = i_item.rgb;
        n_p[0].rem   = QW'(i_item.v) * QW'(i_item.n - 1'b1);
        n_p[0].iq    = '0;
        for (int j = 1; j <= ST_LAST; j++) begin
            n_p[j] = r_p[j-1];
            if (j <= AW) begin
                b  = AW - j;
                sh = QW'(r_p[j-1].d) << b;
                if (r_p[j-1].rem >= sh) begin
                    n_p[j].rem   = r_p[j-1].rem - sh;
                    n_p[j].iq[b] = 1'b1;
                end
            end else if (j == ST_MEM) begin
                n_p[j].r = r_p[j-1].rem[15:0];
            end else if (j == ST_NUM) begin
                n_p[j].c0 = r_rd0;
                for (int c = 0; c < 3; c++) begin
                    num = 24'(r_rd0[8*c +: 8]) * 24'(r_p[j-1].d - r_p[j-1].r)
                        + 24'(r_rd1[8*c +: 8]) * 24'(r_p[j-1].r);
                    n_p[j].rem2[c] = {1'b0, num, 1'b0} + RW'(r_p[j-1].d);
                    n_p[j].res[c]  = '0;
                end
            end else begin
                b   = 7 - (j - ST_NUM - 1);
                sh2 = RW'({r_p[j-1].d, 1'b0}) << b;
                for (int c = 0; c < 3; c++) begin
                    if (r_p[j-1].rem2[c] >= sh2) begin
                        n_p[j].rem2[c]   = r_p[j-1].rem2[c] - sh2;
                        n_p[j].res[c][b] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= ST_LAST; j++) begin
                r_p[j].valid <= 1'b0;
            end
        end else if (w_en) begin
            for (int j = 0; j <= ST_LAST; j++) begin
                r_p[j] <= n_p[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_p[AW].valid && r_p[AW].cls == CL_WRITE
                && 32'(r_p[AW].idx) < CMAP_DEPTH) begin
                r_mem[AW'(r_p[AW].idx)] <= r_p[AW].rgb;
            end
            r_rd0 <= r_mem[w_a0];
            r_rd1 <= r_mem[w_a1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_p[ST_LAST].valid && r_p[ST_LAST].cls != CL_WRITE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            case (r_p[ST_LAST].cls)
                CL_LERP: begin
                    {r_red, r_green, r_blue} <= {r_p[ST_LAST].res[2],
                        r_p[ST_LAST].res[1], r_p[ST_LAST].res[0]};
                end
                CL_FIRST, CL_LAST: begin
                    {r_red, r_green, r_blue} <= r_p[ST_LAST].c0;
                end
                default: begin
                    {r_red, r_green, r_blue} <= '0;
                end
            endcase
            r_alpha <= (r_p[ST_LAST].cls == CL_ZERO) ? 8'd0
                     : alpha_of(i_cfg.opacity_percent);
        end
    end

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p[AW].valid && r_p[AW].cls == CL_LERP
        |-> NW'(r_p[AW].iq) + NW'(1) < r_p[AW].n)
        else $error("interval index past last pair");

    a_frac_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p[AW].valid && r_p[AW].cls == CL_LERP |-> r_p[AW].rem < QW'(r_p[AW].d))
        else $error("fraction not below span");

    a_round_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p[ST_LAST].valid && r_p[ST_LAST].cls == CL_LERP
        |-> r_p[ST_LAST].rem2[0] < RW'({r_p[ST_LAST].d, 1'b0}))
        else $error("channel quotient overflow");

endmodule
